// File: hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg: shared types and constants for the modular exponentiation unit
// Field widths, stream packing, controller states and the command/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int BASE_W      = 32;
    localparam int EXP_FIELD_W = 32;
    localparam int MOD_FIELD_W = 31;
    localparam int RES_W       = 31;

    // Input stream: base_value, exponent, modulus from the lowest bit up
    localparam int BASE_LSB    = 0;
    localparam int EXP_LSB     = BASE_LSB + BASE_W;
    localparam int MOD_LSB     = EXP_LSB + EXP_FIELD_W;
    localparam int S_TDATA_W   = ((MOD_LSB + MOD_FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((RES_W + 7) / 8) * 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_BASE_WAIT,
        ST_LOOP,
        ST_ACC_RED,
        ST_ACC_WAIT,
        ST_SQ_MUL,
        ST_SQ_RED,
        ST_SQ_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_ONE,
        ACC_ZERO,
        ACC_INIT,
        ACC_RED
    } acc_op_t;

    typedef struct packed {
        logic    load_in;
        logic    mul_en;
        logic    mul_sq;
        logic    red_start;
        logic    red_src_prod;
        acc_op_t acc_op;
        logic    sq_load;
        logic    shift_exp;
        logic    out_load;
    } mexp_cmd_t;

    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
        logic mod_zero;
        logic red_busy;
        logic red_done;
    } mexp_status_t;

endpackage

// File: hdl/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit: base^exponent mod modulus
// Binary exponentiation over one shared multiplier and reduction unit.
// ----------------------------------------------------------------------------
// One item in, one result out. The base is first reduced by the modulus,
// then the exponent is scanned from its low bit: each set bit multiplies the
// running square into the result, each bit squares the running square. Every
// modular multiplication is a registered multiplier product followed by a
// reduction at two quotient bits per cycle. One item is worked at a time; a
// finished result waits in the output register while the next item is
// accepted. A zero exponent gives 1 for any modulus; a zero modulus with a
// nonzero exponent gives 0.
module modular_exponentiation_unit #(
    parameter int EXP_BITS = 32,
    parameter int MOD_BITS = 31
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // base_value [31:0], exponent [63:32], modulus [94:64], zero [95]
    input  logic [mexp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // power_result [30:0], zero [31]
    output logic [mexp_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    mexp_pkg::mexp_cmd_t        cmd;
    mexp_pkg::mexp_status_t     status;
    logic [mexp_pkg::RES_W-1:0] result;

    mexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    mexp_datapath #(
        .EXP_BITS (EXP_BITS),
        .MOD_BITS (MOD_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_data (s_axis_tdata),
        .status  (status),
        .result  (result)
    );

    assign m_axis_tdata = mexp_pkg::M_TDATA_W'(result);

`ifndef SYNTH
    // one item at a time: no second accept right after the first
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    // never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register loaded over a pending result");

    // the reduction unit is started only when idle
    a_red_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.red_start |-> !status.red_busy)
        else $error("reduction started while busy");
`endif

endmodule

// File: hdl/mexp_reduce.sv
// ----------------------------------------------------------------------------
// mexp_reduce: iterative modular reduction
// Computes x mod m by restoring long division, two dividend bits per cycle.
// ----------------------------------------------------------------------------
module mexp_reduce #(
    parameter int MOD_BITS = 31,
    parameter int RED_W    = 62
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [RED_W-1:0]    x_in,
    input  logic [MOD_BITS-1:0] m,
    output logic                busy,
    output logic                done,
    output logic [MOD_BITS-1:0] rem
);

    localparam int RED_STEPS = RED_W / 2;
    localparam int CNT_W     = $clog2(RED_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RED_STEPS - 1);

    logic [RED_W-1:0]    x_reg, x_next;
    logic [MOD_BITS-1:0] r_reg, r_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [MOD_BITS:0]   m_ext;
    logic [MOD_BITS:0]   t1, d1, t2, d2;
    logic [MOD_BITS-1:0] r1, r2;

    assign m_ext = {1'b0, m};

    // Two restoring steps: shift in a dividend bit, subtract when it fits
    always_comb
    begin
        t1 = {r_reg, x_reg[RED_W-1]};
        d1 = t1 - m_ext;
        r1 = (t1 >= m_ext) ? d1[MOD_BITS-1:0] : t1[MOD_BITS-1:0];
        t2 = {r1, x_reg[RED_W-2]};
        d2 = t2 - m_ext;
        r2 = (t2 >= m_ext) ? d2[MOD_BITS-1:0] : t2[MOD_BITS-1:0];
    end

    always_comb
    begin
        x_next    = x_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = x_in;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next   = x_reg << 2;
            r_next   = r2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        r_reg <= r_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = r_reg;

endmodule

// File: hdl/mexp_datapath.sv
// ----------------------------------------------------------------------------
// mexp_datapath: operand registers, multiplier and reduction unit
// Holds exponent, modulus, running result and running square; executes
// the commands issued by the controller.
// ----------------------------------------------------------------------------
module mexp_datapath #(
    parameter int EXP_BITS = 32,
    parameter int MOD_BITS = 31
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mexp_pkg::mexp_cmd_t               cmd,
    input  logic [mexp_pkg::S_TDATA_W-1:0]    in_data,
    output mexp_pkg::mexp_status_t            status,
    output logic [mexp_pkg::RES_W-1:0]        result
);

    localparam int EXP_W  = (EXP_BITS > mexp_pkg::EXP_FIELD_W) ? mexp_pkg::EXP_FIELD_W
                                                             : EXP_BITS;
    localparam int PROD_W = 2 * MOD_BITS;
    localparam int RED_W  = (PROD_W > mexp_pkg::BASE_W) ? PROD_W : mexp_pkg::BASE_W;

    logic [mexp_pkg::BASE_W-1:0] base_reg;
    logic [EXP_W-1:0]            exp_reg;
    logic [MOD_BITS-1:0]         mod_reg;
    logic [MOD_BITS-1:0]         acc_reg, acc_next;
    logic [MOD_BITS-1:0]         sq_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic [mexp_pkg::RES_W-1:0]  out_reg;

    logic [MOD_BITS-1:0] mul_a;
    logic [PROD_W-1:0]   prod_full;
    logic [RED_W-1:0]    red_x;
    logic                red_busy;
    logic                red_done;
    logic [MOD_BITS-1:0] red_rem;

    assign mul_a     = cmd.mul_sq ? sq_reg : acc_reg;
    assign prod_full = PROD_W'(mul_a) * PROD_W'(sq_reg);
    assign red_x     = cmd.red_src_prod ? RED_W'(prod_reg) : RED_W'(base_reg);

    mexp_reduce #(
        .MOD_BITS (MOD_BITS),
        .RED_W    (RED_W)
    ) u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.red_start),
        .x_in  (red_x),
        .m     (mod_reg),
        .busy  (red_busy),
        .done  (red_done),
        .rem   (red_rem)
    );

    always_comb
    begin
        unique case (cmd.acc_op)
            mexp_pkg::ACC_HOLD: acc_next = acc_reg;
            mexp_pkg::ACC_ONE:  acc_next = MOD_BITS'(1);
            mexp_pkg::ACC_ZERO: acc_next = '0;
            // 1 mod m: zero only for a modulus of one
            mexp_pkg::ACC_INIT: acc_next = (mod_reg == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
            mexp_pkg::ACC_RED:  acc_next = red_rem;
            default:            acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            base_reg <= in_data[mexp_pkg::BASE_LSB +: mexp_pkg::BASE_W];
            exp_reg  <= in_data[mexp_pkg::EXP_LSB +: EXP_W];
            mod_reg  <= in_data[mexp_pkg::MOD_LSB +: MOD_BITS];
        end
        else if (cmd.shift_exp)
        begin
            exp_reg <= exp_reg >> 1;
        end
        acc_reg <= acc_next;
        if (cmd.sq_load)
        begin
            sq_reg <= red_rem;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_full;
        end
        if (cmd.out_load)
        begin
            out_reg <= mexp_pkg::RES_W'(acc_reg);
        end
    end

    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_lsb  = exp_reg[0];
    assign status.mod_zero = (mod_reg == '0);
    assign status.red_busy = red_busy;
    assign status.red_done = red_done;
    assign result          = out_reg;

endmodule

// File: hdl/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl: sequencing state machine
// Walks the exponent bits, issuing multiply and reduce commands, and owns
// the stream handshakes and the output valid flag.
// ----------------------------------------------------------------------------
module mexp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  mexp_pkg::mexp_status_t status,
    output mexp_pkg::mexp_cmd_t    cmd
);

    mexp_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        cmd.acc_op     = mexp_pkg::ACC_HOLD;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = mexp_pkg::ST_START;
                end
            end
            mexp_pkg::ST_START:
            begin
                if (status.exp_zero)
                begin
                    cmd.acc_op = mexp_pkg::ACC_ONE;
                    state_next = mexp_pkg::ST_FINISH;
                end
                else if (status.mod_zero)
                begin
                    cmd.acc_op = mexp_pkg::ACC_ZERO;
                    state_next = mexp_pkg::ST_FINISH;
                end
                else
                begin
                    // reduce the base before the first product
                    cmd.acc_op    = mexp_pkg::ACC_INIT;
                    cmd.red_start = 1'b1;
                    state_next    = mexp_pkg::ST_BASE_WAIT;
                end
            end
            mexp_pkg::ST_BASE_WAIT:
            begin
                if (status.red_done)
                begin
                    cmd.sq_load = 1'b1;
                    state_next  = mexp_pkg::ST_LOOP;
                end
            end
            mexp_pkg::ST_LOOP:
            begin
                if (status.exp_zero)
                begin
                    state_next = mexp_pkg::ST_FINISH;
                end
                else if (status.exp_lsb)
                begin
                    cmd.mul_en = 1'b1;
                    state_next = mexp_pkg::ST_ACC_RED;
                end
                else
                begin
                    cmd.mul_en = 1'b1;
                    cmd.mul_sq = 1'b1;
                    state_next = mexp_pkg::ST_SQ_RED;
                end
            end
            mexp_pkg::ST_ACC_RED:
            begin
                cmd.red_start    = 1'b1;
                cmd.red_src_prod = 1'b1;
                state_next       = mexp_pkg::ST_ACC_WAIT;
            end
            mexp_pkg::ST_ACC_WAIT:
            begin
                if (status.red_done)
                begin
                    cmd.acc_op = mexp_pkg::ACC_RED;
                    state_next = mexp_pkg::ST_SQ_MUL;
                end
            end
            mexp_pkg::ST_SQ_MUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_sq = 1'b1;
                state_next = mexp_pkg::ST_SQ_RED;
            end
            mexp_pkg::ST_SQ_RED:
            begin
                cmd.red_start    = 1'b1;
                cmd.red_src_prod = 1'b1;
                state_next       = mexp_pkg::ST_SQ_WAIT;
            end
            mexp_pkg::ST_SQ_WAIT:
            begin
                if (status.red_done)
                begin
                    cmd.sq_load   = 1'b1;
                    cmd.shift_exp = 1'b1;
                    state_next    = mexp_pkg::ST_LOOP;
                end
            end
            mexp_pkg::ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = mexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == mexp_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: dv/modular_exponentiation_unit_tb.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit_tb: self-checking bench for base^exp mod m
// Drives operand items into the slave stream and checks every power that
// leaves the master stream against a predictor based on repeated squaring.
// The run uses directed corner items and then random items in three phases
// of sender and receiver idling. It includes one long receiver hold-off
// that backs up the block.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit_tb;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int          LONG_HOLD   = 6000;
    localparam int          PHASE_ITEMS = 90;

    typedef struct {
        bit [mexp_pkg::BASE_W-1:0]      base_value;
        bit [mexp_pkg::EXP_FIELD_W-1:0] exponent;
        bit [mexp_pkg::MOD_FIELD_W-1:0] modulus;
    } operands_t;

    class power_tracker;
        bit [mexp_pkg::RES_W-1:0] expected_powers[$];
        int                       mismatches = 0;

        function bit [mexp_pkg::RES_W-1:0] power_mod(operands_t op);
            bit [63:0] md;
            bit [63:0] sq;
            bit [63:0] acc;
            bit [31:0] ex;
            if (op.exponent == 0)
                return mexp_pkg::RES_W'(1);
            if (op.modulus == 0)
                return '0;
            md  = op.modulus;
            sq  = op.base_value % md;
            acc = 1 % md;
            ex  = op.exponent;
            while (ex != 0)
            begin
                if (ex[0])
                    acc = (acc * sq) % md;
                sq = (sq * sq) % md;
                ex = ex >> 1;
            end
            return acc[mexp_pkg::RES_W-1:0];
        endfunction

        function void note_operands(operands_t op);
            expected_powers.insert(expected_powers.size(), power_mod(op));
        endfunction

        function void check_power(bit [mexp_pkg::RES_W-1:0] power_result);
            bit [mexp_pkg::RES_W-1:0] want;
            if (expected_powers.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual power_result %0d",
                         $time, power_result);
                mismatches++;
                return;
            end
            want = expected_powers.pop_front();
            if (power_result !== want)
            begin
                $display("%0t: power_result mismatch, expected %0d, actual %0d",
                         $time, want, power_result);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_powers.size();
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [mexp_pkg::S_TDATA_W-1:0] s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [mexp_pkg::M_TDATA_W-1:0] m_axis_tdata;

    power_tracker powers = new();
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           hold_request  = 1'b0;
    bit           hold_taken    = 1'b0;
    int           hold_left     = 0;
    int unsigned  cycle_count   = 0;

    modular_exponentiation_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: check accepted results, then pick tready for the next edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                powers.check_power(m_axis_tdata[mexp_pkg::RES_W-1:0]);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left     = hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_operands(input bit [31:0] b, input bit [31:0] e, input bit [30:0] m);
        operands_t                      op;
        logic [mexp_pkg::S_TDATA_W-1:0] word;
        op.base_value = b;
        op.exponent   = e;
        op.modulus    = m;
        word          = '0;
        word[mexp_pkg::BASE_LSB +: mexp_pkg::BASE_W]     = b;
        word[mexp_pkg::EXP_LSB +: mexp_pkg::EXP_FIELD_W] = e;
        word[mexp_pkg::MOD_LSB +: mexp_pkg::MOD_FIELD_W] = m;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        powers.note_operands(op);
    endtask

    // Mostly short exponents keep the run short; a few span all 32 bits
    task automatic send_random_operands();
        bit [31:0] b;
        bit [31:0] e;
        bit [30:0] m;
        int        len;
        case ($urandom_range(9))
            0:       b = '0;
            1:       b = '1;
            2:       b = $urandom_range(0, 100);
            default: b = $urandom;
        endcase
        len = $urandom_range(1, 10);
        case ($urandom_range(19))
            0:       e = '0;
            1, 2:    e = $urandom;
            default: e = ($urandom & ((32'd1 << len) - 1)) | (32'd1 << (len - 1));
        endcase
        case ($urandom_range(19))
            0:       m = '0;
            1:       m = 31'd1;
            2:       m = '1;
            3, 4:    m = 31'($urandom_range(2, 64));
            default: m = 31'($urandom);
        endcase
        send_operands(b, e, m);
    endtask

    task automatic drain_powers();
        while (powers.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 27;
        recv_idle_pct = 68;

        // zero exponent gives 1 for any modulus, also one and zero
        send_operands(32'd7, 32'd0, 31'd1);
        send_operands(32'd7, 32'd0, 31'd0);
        send_operands(32'hFFFF_FFFF, 32'd0, 31'h7FFF_FFFF);
        // modulus of one gives 0
        send_operands(32'd12345, 32'd9, 31'd1);
        // modulus of zero with a nonzero exponent gives 0
        send_operands(32'hDEAD_BEEF, 32'hFFFF_FFFF, 31'd0);
        send_operands(32'd0, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'd1, 31'h7FFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'd2, 31'h7FFF_FFFE);
        send_operands(32'd3, 32'h8000_0000, 31'h7FFF_FFFF);
        send_operands(32'd5, 32'd13, 31'd2);
        // base equal to, a multiple of, and just below the modulus
        send_operands(32'd1000, 32'd3, 31'd1000);
        send_operands(32'd3000, 32'd5, 31'd1000);
        send_operands(32'd999, 32'd7, 31'd1000);
        send_operands(32'h8000_0000, 32'h5555_5555, 31'h4000_0000);
        send_operands(32'h5555_5555, 32'hAAAA_AAAA, 31'h2AAA_AAAB);
        send_operands(32'd2, 32'd30, 31'h7FFF_FFFF);

        repeat (PHASE_ITEMS) send_random_operands();
        s_axis_tvalid <= 1'b0;
        drain_powers();

        send_idle_pct = 68;
        recv_idle_pct = 27;
        repeat (PHASE_ITEMS) send_random_operands();

        // hold the receiver off while items keep coming so the block backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        repeat (PHASE_ITEMS) send_random_operands();
        s_axis_tvalid <= 1'b0;

        drain_powers();
        repeat (40) @(posedge clk);
        if (powers.mismatches == 0 && powers.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
